[rtl/dual_channel_fir_filter_core_defines.svh]
// Assertion macros for the dual-channel FIR filter core.
// No dependencies; included by the files that carry assertions.
`ifndef DUAL_CHANNEL_FIR_FILTER_CORE_DEFINES_SVH
`define DUAL_CHANNEL_FIR_FILTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define DCFIR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset.
`define DCFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DCFIR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define DCFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/dcfir_pkg.sv]
// Shared types, constants and coefficient ROM for the dual-channel FIR filter core.
// No dependencies.
`default_nettype none

package dcfir_pkg;

    localparam int DEF_TAPS        = 100;
    localparam int DEF_CHANNELS    = 2;
    localparam int DEF_SAMPLE_BITS = 16;

    // Q0.16 coefficients: 1/100 on every tap but one, 2/100 on that one tap
    localparam int COEF_W      = 11;
    localparam int COEF_BASE   = 655;
    localparam int COEF_DOUBLE = 1311;
    localparam int DOUBLE_TAP  = 65;
    localparam int FRAC_BITS   = 16;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    function automatic logic [COEF_W-1:0] coef_of(input int tap);
        logic [COEF_W-1:0] c;
        if (tap == DOUBLE_TAP) begin
            c = COEF_W'(COEF_DOUBLE);
        end else begin
            c = COEF_W'(COEF_BASE);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/dual_channel_fir_filter_core.sv]
// Dual-channel FIR filter core: per-channel delay lines in one RAM, one MAC per cycle.
// Depends on dcfir_pkg and dual_channel_fir_filter_core_defines.svh.
//
//  channel   signals                                  dir
//  --------  ---------------------------------------  ---
//  input     i_in_valid, o_in_ready, i_channel, i_sample   in
//  output    o_out_valid, i_out_ready, o_filtered          out
//
// Each sample's pass is set by the single RAM read port: one tap is read and
// multiplied per cycle, then a three-deep read/multiply/accumulate drain runs
// and the output register is loaded. After reset a clearing pass zeroes every
// address of the delay RAM; no request is taken until it ends. A result that
// is not taken holds the core in its final state; the next request is taken
// once the result register moves.
`default_nettype none

`include "dual_channel_fir_filter_core_defines.svh"

module dual_channel_fir_filter_core #(
    parameter int TAPS        = dcfir_pkg::DEF_TAPS,
    parameter int CHANNELS    = dcfir_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = dcfir_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_channel,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_filtered
);

    import dcfir_pkg::*;

    localparam int DEPTH  = CHANNELS * TAPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TAP_W  = $clog2(TAPS);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(TAPS) + 2;
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    t_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_mem_q;

    logic [TAP_W-1:0]  r_wptr [CHANNELS];
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_base;
    logic [TAP_W-1:0]  r_idx;
    logic [TAP_W-1:0]  r_k;
    logic [TAP_W-1:0]  r_rd_k;
    logic              r_rd_v;
    logic              r_pr_v;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_filtered;

    logic              w_accept;
    logic              w_issue;
    logic              w_clr;
    logic              w_load;
    logic [CH_W-1:0]   w_ch;
    logic [TAP_W-1:0]  w_ptr;
    logic [ADDR_W-1:0] w_in_base;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [SAMPLE_BITS-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic signed [COEF_W:0]   w_coef;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_sat;

    // Channel number taken modulo CHANNELS
    assign w_ch      = (CHANNELS == 1) ? '0 : CH_W'(i_channel);
    assign w_ptr     = r_wptr[w_ch];
    assign w_in_base = ADDR_W'(w_ch) * ADDR_W'(TAPS);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_RUN;
            end
            S_RUN: begin
                if (r_k == TAP_W'(TAPS - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_rd_v && !r_pr_v) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_clr      = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            S_CLEAR: w_clr      = 1'b1;
            S_IDLE:  o_in_ready = 1'b1;
            S_RUN:   w_issue    = 1'b1;
            S_DRAIN: ;
            S_DONE:  w_load     = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // Single write port: zero fill during clearing, new sample on request
    always_comb begin
        w_we    = w_clr || w_accept;
        w_waddr = w_clr ? r_clr_addr : (w_in_base + ADDR_W'(w_ptr));
        w_wdata = w_clr ? '0 : i_sample;
    end

    assign w_raddr = r_base + ADDR_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_mem[w_raddr];
    end

    assign w_coef = signed'({1'b0, coef_of(int'(r_rd_k))});
    assign w_prod = PROD_W'(r_mem_q) * PROD_W'(w_coef);

    // Round half up, then saturate
    assign w_rnd = (r_acc + HALF) >>> FRAC_BITS;
    always_comb begin
        if (w_rnd > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_rnd < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_rnd;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rd_v      <= 1'b0;
            r_pr_v      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wptr[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_rd_v  <= w_issue;
            r_pr_v  <= r_rd_v;
            if (w_clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (w_accept) begin
                r_wptr[w_ch] <= (w_ptr == TAP_W'(TAPS - 1)) ? '0 : w_ptr + TAP_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= w_in_base;
            r_idx  <= w_ptr;
            r_k    <= '0;
            r_acc  <= '0;
        end else begin
            if (w_issue) begin
                // walk backward from the newest sample
                r_idx <= (r_idx == '0) ? TAP_W'(TAPS - 1) : r_idx - TAP_W'(1);
                r_k   <= r_k + TAP_W'(1);
            end
            if (r_pr_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        r_rd_k <= r_k;
        r_prod <= w_prod;
        if (w_load) begin
            r_filtered <= SAMPLE_BITS'(w_sat);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

    `DCFIR_ASSERT_NOW(a_idle_pipe_empty, i_clk, i_rst_n, o_in_ready,
        !r_rd_v && !r_pr_v, "request taken with MAC pipeline busy")
    `DCFIR_ASSERT_NEXT(a_accept_runs, i_clk, i_rst_n, w_accept,
        r_state == S_RUN, "request did not start a pass")
    `DCFIR_ASSERT_NOW(a_clear_no_result, i_clk, i_rst_n, r_state == S_CLEAR,
        !o_out_valid && !o_in_ready, "result or request during clearing")

endmodule

`default_nettype wire
